### hdl/mll_pkg.sv
// ----------------------------------------------------------------------------
// mll_pkg
// types, character codes and token kind codes shared by the lexer
// ----------------------------------------------------------------------------
package mll_pkg;

  localparam int MAX_TOKEN_LEN_DEF = 256;

  localparam logic [2:0] KIND_TAG    = 3'd0;
  localparam logic [2:0] KIND_NUMBER = 3'd1;
  localparam logic [2:0] KIND_IDENT  = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_UNREC  = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [8*8-1:0] OPEN_TXT  = "indicium";
  localparam logic [8*9-1:0] CLOSE_TXT = "/indicium";
  localparam logic [3:0] OPEN_LEN  = 4'd8;
  localparam logic [3:0] CLOSE_LEN = 4'd9;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } lex_in_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [7:0]  token_char;
    logic        empty_token;
    logic        token_end;
    logic [15:0] token_line;
    logic        truncated;
    logic        run_last;
  } lex_out_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic       empty;
    logic       fin;
    logic       trunc;
  } slot_t;

  function automatic logic [7:0] brace_char(input logic close, input logic [3:0] j);
    logic [7:0] c;
    c = CH_NUL;
    if (close) begin
      if (j < CLOSE_LEN) c = CLOSE_TXT[8*(8 - int'(j)) +: 8];
    end else begin
      if (j < OPEN_LEN) c = OPEN_TXT[8*(7 - int'(j)) +: 8];
    end
    return c;
  endfunction

  function automatic logic is_num_char(input logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_DASH;
  endfunction

  function automatic logic is_letter_char(input logic [7:0] b);
    return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
  endfunction

endpackage

### hdl/markup_language_lexer_unit.sv
// ----------------------------------------------------------------------------
// markup_language_lexer_unit
// streaming lexer: one text byte in, one token character out per result
// ----------------------------------------------------------------------------
// A text byte is taken in every cycle while each byte gives at most one
// result and out_stall is low. The lexer state is updated as a byte is
// accepted and the results it causes are kept in a plan register, which a
// single output register drains at one result per cycle while out_stall
// is low; a byte giving several results therefore holds in_stall high until
// its last result is loaded (an opening brace gives 8, a closing brace 9,
// and a token end before a brace adds one, up to 10). A byte giving no
// result (whitespace, a kept but held character) does not stall the input.
module markup_language_lexer_unit
  import mll_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  lex_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output lex_out_t out_data
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

  typedef enum logic [2:0] {
    M_IDLE, M_TAG, M_NUM, M_IDENT, M_STR_SKIP, M_STR_FIRST, M_STR_BODY
  } mode_t;

  typedef enum logic [1:0] {TAIL_NONE, TAIL_UNREC, TAIL_OPEN, TAIL_CLOSE} tail_t;

  typedef struct packed {
    mode_t            mode;
    logic [7:0]       hc;
    logic             hv;
    logic             bp;
    logic [LEN_W-1:0] len;
    logic             ov;
  } lst_t;

  typedef struct packed {
    lst_t       st;
    logic [1:0] n;
    slot_t      s0;
    slot_t      s1;
  } acc_t;

  function automatic lst_t clean_state();
    return '{mode: M_IDLE, hc: 8'h00, hv: 1'b0, bp: 1'b0, len: '0, ov: 1'b0};
  endfunction

  function automatic logic [2:0] kind_of(input mode_t m);
    logic [2:0] k;
    unique case (m)
      M_TAG:   k = KIND_TAG;
      M_NUM:   k = KIND_NUMBER;
      M_IDENT: k = KIND_IDENT;
      default: k = KIND_STRING;
    endcase
    return k;
  endfunction

  function automatic acc_t emit(input acc_t a, input slot_t r);
    acc_t o;
    o = a;
    if (a.n == 2'd0) o.s0 = r;
    else o.s1 = r;
    o.n = a.n + 2'd1;
    return o;
  endfunction

  function automatic acc_t app(input acc_t a, input logic [7:0] b);
    acc_t  o;
    slot_t r;
    o = a;
    r = '{kind: kind_of(a.st.mode), ch: a.st.hc, empty: 1'b0, fin: 1'b0, trunc: 1'b0};
    if (a.st.len < LEN_W'(MAX_TOKEN_LEN)) begin
      if (a.st.hv) o = emit(o, r);
      o.st.hc  = b;
      o.st.hv  = 1'b1;
      o.st.len = a.st.len + LEN_W'(1);
    end else begin
      o.st.ov = 1'b1;
    end
    return o;
  endfunction

  function automatic acc_t finish(input acc_t a);
    acc_t  o;
    slot_t r;
    o = a;
    if (a.st.bp) begin
      o.st.bp = 1'b0;
      o = app(o, CH_BAR);
    end
    r.kind  = kind_of(o.st.mode);
    r.ch    = o.st.hv ? o.st.hc : CH_NUL;
    r.empty = !o.st.hv;
    r.fin   = 1'b1;
    r.trunc = o.st.ov;
    o = emit(o, r);
    o.st = clean_state();
    return o;
  endfunction

  lst_t        st_r;
  logic [15:0] line_r;

  logic        plan_valid_r;
  slot_t       s0_r, s1_r;
  logic [1:0]  n_r;
  tail_t       tail_r;
  logic [7:0]  tail_ch_r;
  logic [15:0] plan_line_r;
  logic [3:0]  total_r;
  logic [3:0]  idx_r;

  logic        out_valid_r;
  lex_out_t    out_data_r;

  // next state and result plan for the byte at the input
  acc_t        a;
  tail_t       tail_nxt;
  logic [3:0]  total_nxt;
  logic        line_inc;
  logic        eot;
  logic        go_idle;
  logic [7:0]  b;

  always_comb begin
    b        = in_data.text_byte;
    eot      = in_data.end_of_text || (b == CH_NUL);
    a        = '{st: st_r, n: 2'd0, s0: '0, s1: '0};
    tail_nxt = TAIL_NONE;
    line_inc = 1'b0;
    go_idle  = 1'b0;
    if (eot) begin
      if (st_r.mode != M_IDLE) a = finish(a);
      a.st = clean_state();
    end else begin
      unique case (st_r.mode)
        M_TAG: begin
          if (b == CH_GT) a = finish(a);
          else a = app(a, b);
        end
        M_NUM: begin
          if (is_num_char(b)) a = app(a, b);
          else begin
            a = finish(a);
            go_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_letter_char(b)) a = app(a, b);
          else begin
            a = finish(a);
            go_idle = 1'b1;
          end
        end
        M_STR_SKIP: a.st.mode = M_STR_FIRST;
        M_STR_FIRST: begin
          a = app(a, b);
          a.st.mode = M_STR_BODY;
        end
        M_STR_BODY: begin
          if (st_r.bp) begin
            a.st.bp = 1'b0;
            if (b == CH_BAR) a = finish(a);
            else begin
              a = app(a, CH_BAR);
              a = app(a, b);
            end
          end else if (b == CH_BAR) begin
            a.st.bp = 1'b1;
          end else begin
            a = app(a, b);
          end
        end
        default: begin
          a.st = clean_state();
          go_idle = 1'b1;
        end
      endcase
    end
    if (go_idle) begin
      priority if (b == CH_LT) begin
        a.st.mode = M_TAG;
      end else if (is_num_char(b)) begin
        a.st.mode = M_NUM;
        a.st.hc   = b;
        a.st.hv   = 1'b1;
        a.st.len  = LEN_W'(1);
      end else if (is_letter_char(b)) begin
        a.st.mode = M_IDENT;
        a.st.hc   = b;
        a.st.hv   = 1'b1;
        a.st.len  = LEN_W'(1);
      end else if (b == CH_BAR) begin
        a.st.mode = M_STR_SKIP;
      end else if (b == CH_LBRACE) begin
        tail_nxt = TAIL_OPEN;
      end else if (b == CH_RBRACE) begin
        tail_nxt = TAIL_CLOSE;
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
        line_inc = (b == CH_LF) && (line_r != 16'hFFFF);
      end else begin
        tail_nxt = TAIL_UNREC;
      end
    end
    unique case (tail_nxt)
      TAIL_UNREC: total_nxt = {2'b00, a.n} + 4'd1;
      TAIL_OPEN:  total_nxt = {2'b00, a.n} + OPEN_LEN;
      TAIL_CLOSE: total_nxt = {2'b00, a.n} + CLOSE_LEN;
      default:    total_nxt = {2'b00, a.n};
    endcase
  end

  // result at the current plan position
  slot_t      cur;
  logic [3:0] j;
  logic       out_load;
  logic       plan_done;
  logic       in_acc;

  always_comb begin
    j = idx_r - {2'b00, n_r};
    if (idx_r < {2'b00, n_r}) begin
      cur = idx_r[0] ? s1_r : s0_r;
    end else begin
      unique case (tail_r)
        TAIL_UNREC: cur = '{kind: KIND_UNREC, ch: tail_ch_r, empty: 1'b0, fin: 1'b1,
                            trunc: 1'b0};
        TAIL_OPEN:  cur = '{kind: KIND_TAG, ch: brace_char(1'b0, j), empty: 1'b0,
                            fin: (j == OPEN_LEN - 4'd1), trunc: 1'b0};
        TAIL_CLOSE: cur = '{kind: KIND_TAG, ch: brace_char(1'b1, j), empty: 1'b0,
                            fin: (j == CLOSE_LEN - 4'd1), trunc: 1'b0};
        default:    cur = '0;
      endcase
    end
  end

  assign out_load  = plan_valid_r && (!out_valid_r || !out_stall);
  assign plan_done = out_load && (idx_r == total_r - 4'd1);
  assign in_stall  = plan_valid_r && !plan_done;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= clean_state();
      line_r       <= 16'd1;
      plan_valid_r <= 1'b0;
      idx_r        <= 4'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r         <= a.st;
        line_r       <= eot ? 16'd1 : (line_inc ? line_r + 16'd1 : line_r);
        plan_valid_r <= (total_nxt != 4'd0);
        idx_r        <= 4'd0;
      end else if (plan_done) begin
        plan_valid_r <= 1'b0;
      end else if (out_load) begin
        idx_r <= idx_r + 4'd1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // plan and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s0_r        <= a.s0;
      s1_r        <= a.s1;
      n_r         <= a.n;
      tail_r      <= tail_nxt;
      tail_ch_r   <= b;
      plan_line_r <= line_r;
      total_r     <= total_nxt;
    end
    if (out_load) begin
      out_data_r <= '{token_kind: cur.kind, token_char: cur.ch, empty_token: cur.empty,
                      token_end: cur.fin, token_line: plan_line_r, truncated: cur.trunc,
                      run_last: (idx_r == total_r - 4'd1)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_idx_in_plan: assert property (@(posedge clk) disable iff (!rst_n)
    plan_valid_r |-> (idx_r < total_r))
    else $error("plan index past its last result");

  a_plan_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && plan_valid_r) |-> plan_done)
    else $error("new beat taken over an unfinished plan");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != 16'd0)
    else $error("line counter reached zero");

  a_held_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hv |-> (st_r.len != '0))
    else $error("held character with zero token length");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (idx_r == total_r - 4'd1) && !in_acc) |=> !plan_valid_r)
    else $error("plan still busy after its last result");
`endif

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// beat-level test of the markup lexer: a directed token table, a back-pressure
// burst of braces and random text, with every result beat checked against a
// lexer predictor kept in the bench or, for a pinned table row, against the
// result given in that row
module tb;
  import mll_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_LEN = MAX_TOKEN_LEN_DEF;
  localparam int RAND_BEATS = 160;
  localparam int LONG_HOLD = 300;
  localparam string OPEN_WORD = "indicium";
  localparam string CLOSE_WORD = "/indicium";
  localparam lex_out_t NO_RES = '0;

  typedef enum logic [3:0] {
    LX_IDLE, LX_TAG, LX_NUM, LX_IDENT, LX_STR_SKIP, LX_STR_FIRST, LX_STR_BODY
  } lx_mode_e;

  typedef struct packed {
    lex_in_t  beat;
    logic     pinned;
    lex_out_t res;
  } lex_row_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  lex_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  lex_out_t out_data;

  logic     pin_on = 1'b0;
  lex_out_t pin_res = '0;
  logic     tx_rush = 1'b0;
  logic     hold_off_req = 1'b0;
  int       tx_calm = 0;
  int       rx_calm = 0;
  int       beats_sent = 0;
  int       errors = 0;
  int       cycles = 0;

  lex_out_t tok_exp_q[$];
  lex_out_t step_res[$];

  lx_mode_e    lx_mode = LX_IDLE;
  logic [7:0]  held_ch = '0;
  logic        held_ok = 1'b0;
  logic        bar_wait = 1'b0;
  int          tok_len = 0;
  logic        tok_over = 1'b0;
  logic [15:0] ln_count = 16'd1;

  lex_row_t dir_tab [25] = '{
    '{'{"#", 1'b0}, 1'b1, '{KIND_UNREC, "#", 1'b0, 1'b1, 16'd1, 1'b0, 1'b1}},
    '{'{CH_LT, 1'b0}, 1'b0, NO_RES},
    '{'{CH_GT, 1'b0}, 1'b1, '{KIND_TAG, 8'h00, 1'b1, 1'b1, 16'd1, 1'b0, 1'b1}},
    '{'{8'hFF, 1'b0}, 1'b1, '{KIND_UNREC, 8'hFF, 1'b0, 1'b1, 16'd1, 1'b0, 1'b1}},
    '{'{CH_LBRACE, 1'b0}, 1'b0, NO_RES},
    '{'{CH_RBRACE, 1'b0}, 1'b0, NO_RES},
    '{'{"a", 1'b0}, 1'b0, NO_RES},
    '{'{"Z", 1'b0}, 1'b0, NO_RES},
    '{'{"9", 1'b0}, 1'b0, NO_RES},
    '{'{CH_DOT, 1'b0}, 1'b0, NO_RES},
    '{'{CH_DASH, 1'b0}, 1'b0, NO_RES},
    '{'{CH_SPACE, 1'b0}, 1'b0, NO_RES},
    '{'{CH_LF, 1'b0}, 1'b0, NO_RES},
    '{'{CH_BAR, 1'b0}, 1'b0, NO_RES},
    '{'{"x", 1'b0}, 1'b0, NO_RES},
    '{'{CH_BAR, 1'b0}, 1'b0, NO_RES},
    '{'{CH_BAR, 1'b0}, 1'b0, NO_RES},
    '{'{"q", 1'b0}, 1'b0, NO_RES},
    '{'{CH_BAR, 1'b0}, 1'b0, NO_RES},
    '{'{CH_BAR, 1'b0}, 1'b0, NO_RES},
    '{'{CH_LT, 1'b0}, 1'b0, NO_RES},
    '{'{CH_LF, 1'b0}, 1'b0, NO_RES},
    '{'{8'hA5, 1'b1}, 1'b0, NO_RES},
    '{'{CH_BAR, 1'b0}, 1'b0, NO_RES},
    '{'{CH_NUL, 1'b0}, 1'b1, '{KIND_STRING, 8'h00, 1'b1, 1'b1, 16'd1, 1'b0, 1'b1}}
  };

  markup_language_lexer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- lexer predictor ----------------

  function automatic logic num_class(input logic [7:0] b);
    return (b >= "0" && b <= "9") || b == "." || b == "-";
  endfunction

  function automatic logic alpha_class(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic [2:0] mode_kind(input lx_mode_e m);
    case (m)
      LX_TAG:   return KIND_TAG;
      LX_NUM:   return KIND_NUMBER;
      LX_IDENT: return KIND_IDENT;
      default:  return KIND_STRING;
    endcase
  endfunction

  task automatic emit_res(input logic [2:0] kind, input logic [7:0] ch, input logic empty,
                          input logic fin, input logic trunc);
    step_res.push_back('{kind, ch, empty, fin, ln_count, trunc, 1'b0});
  endtask

  task automatic open_token(input lx_mode_e m);
    lx_mode = m;
    held_ch = '0;
    held_ok = 1'b0;
    bar_wait = 1'b0;
    tok_len = 0;
    tok_over = 1'b0;
  endtask

  task automatic keep_char(input logic [7:0] b);
    if (tok_len < MAX_LEN) begin
      if (held_ok) emit_res(mode_kind(lx_mode), held_ch, 1'b0, 1'b0, 1'b0);
      held_ch = b;
      held_ok = 1'b1;
      tok_len++;
    end else begin
      tok_over = 1'b1;
    end
  endtask

  task automatic close_token();
    if (bar_wait) begin
      keep_char(CH_BAR);
      bar_wait = 1'b0;
    end
    emit_res(mode_kind(lx_mode), held_ok ? held_ch : 8'h00, !held_ok, 1'b1, tok_over);
    open_token(LX_IDLE);
  endtask

  task automatic idle_byte(input logic [7:0] b);
    if (b == CH_LT) begin
      open_token(LX_TAG);
    end else if (num_class(b)) begin
      open_token(LX_NUM);
      keep_char(b);
    end else if (alpha_class(b)) begin
      open_token(LX_IDENT);
      keep_char(b);
    end else if (b == CH_BAR) begin
      open_token(LX_STR_SKIP);
    end else if (b == CH_LBRACE) begin
      for (int i = 0; i < 8; i++) emit_res(KIND_TAG, OPEN_WORD[i], 1'b0, i == 7, 1'b0);
    end else if (b == CH_RBRACE) begin
      for (int i = 0; i < 9; i++) emit_res(KIND_TAG, CLOSE_WORD[i], 1'b0, i == 8, 1'b0);
    end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
      if (b == CH_LF && ln_count != 16'hFFFF) ln_count++;
    end else begin
      emit_res(KIND_UNREC, b, 1'b0, 1'b1, 1'b0);
    end
  endtask

  task automatic lex_predict(input lex_in_t d);
    logic [7:0] b;
    lex_out_t   last;
    b = d.text_byte;
    step_res.delete();
    if (d.end_of_text || b == CH_NUL) begin
      if (lx_mode != LX_IDLE) close_token();
      open_token(LX_IDLE);
      ln_count = 16'd1;
    end else begin
      case (lx_mode)
        LX_TAG: begin
          if (b == CH_GT) close_token();
          else keep_char(b);
        end
        LX_NUM: begin
          if (num_class(b)) begin
            keep_char(b);
          end else begin
            close_token();
            idle_byte(b);
          end
        end
        LX_IDENT: begin
          if (alpha_class(b)) begin
            keep_char(b);
          end else begin
            close_token();
            idle_byte(b);
          end
        end
        LX_STR_SKIP: lx_mode = LX_STR_FIRST;
        LX_STR_FIRST: begin
          keep_char(b);
          lx_mode = LX_STR_BODY;
        end
        LX_STR_BODY: begin
          if (bar_wait) begin
            bar_wait = 1'b0;
            if (b == CH_BAR) begin
              close_token();
            end else begin
              keep_char(CH_BAR);
              keep_char(b);
            end
          end else if (b == CH_BAR) begin
            bar_wait = 1'b1;
          end else begin
            keep_char(b);
          end
        end
        default: idle_byte(b);
      endcase
    end
    if (step_res.size() > 0) begin
      last = step_res.pop_back();
      last.run_last = 1'b1;
      step_res.push_back(last);
    end
  endtask

  // ---------------- checking ----------------

  task automatic check_token(input lex_out_t got);
    lex_out_t want;
    if (tok_exp_q.size() == 0) begin
      $error("unexpected result beat: kind %0d char %02h", got.token_kind, got.token_char);
      errors++;
    end else begin
      want = tok_exp_q.pop_front();
      if (got.token_kind !== want.token_kind) begin
        $error("token_kind expected %0d actual %0d", want.token_kind, got.token_kind);
        errors++;
      end
      if (!want.empty_token && got.token_char !== want.token_char) begin
        $error("token_char expected %02h actual %02h", want.token_char, got.token_char);
        errors++;
      end
      if (got.empty_token !== want.empty_token) begin
        $error("empty_token expected %0d actual %0d", want.empty_token, got.empty_token);
        errors++;
      end
      if (got.token_end !== want.token_end) begin
        $error("token_end expected %0d actual %0d", want.token_end, got.token_end);
        errors++;
      end
      if (got.token_line !== want.token_line) begin
        $error("token_line expected %0d actual %0d", want.token_line, got.token_line);
        errors++;
      end
      if (got.truncated !== want.truncated) begin
        $error("truncated expected %0d actual %0d", want.truncated, got.truncated);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last expected %0d actual %0d", want.run_last, got.run_last);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) check_token(out_data);
      if (in_valid && !in_stall) begin
        lex_predict(in_data);
        if (pin_on) tok_exp_q.push_back(pin_res);
        else foreach (step_res[i]) tok_exp_q.push_back(step_res[i]);
      end
    end
  end

  // ---------------- idling ----------------

  function automatic int draw_idle(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 14);
  endfunction

  initial begin
    int n;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = draw_idle(rx_calm);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // ---------------- stimulus ----------------

  task automatic send_beat(input lex_in_t d, input logic pinned, input lex_out_t res);
    int gap;
    gap = tx_rush ? 0 : draw_idle(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    pin_on <= pinned;
    pin_res <= res;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_ch(input logic [7:0] b);
    send_beat('{b, 1'b0}, 1'b0, NO_RES);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (tok_exp_q.size() != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 1) return CH_LO_A + 8'($urandom_range(0, 25));
    return CH_UP_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_numeral();
    int k;
    k = $urandom_range(0, 11);
    if (k < 10) return CH_ZERO + 8'(k);
    return (k == 10) ? CH_DOT : CH_DASH;
  endfunction

  function automatic logic [7:0] rand_tag_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    return (b == CH_GT) ? CH_SPACE : b;
  endfunction

  task automatic lex_snippet();
    int k;
    k = $urandom_range(0, 19);
    if (k <= 3) begin
      repeat ($urandom_range(1, 8)) send_ch(rand_letter());
    end else if (k <= 6) begin
      repeat ($urandom_range(1, 8)) send_ch(rand_numeral());
    end else if (k <= 8) begin
      send_ch(CH_LT);
      repeat ($urandom_range(0, 6)) send_ch(rand_tag_byte());
      if ($urandom_range(0, 7) != 0) send_ch(CH_GT);
    end else if (k <= 10) begin
      send_ch(CH_BAR);
      send_ch(8'($urandom_range(1, 255)));
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 3) == 0) send_ch(CH_BAR);
        else send_ch(8'($urandom_range(1, 255)));
      end
      send_ch(CH_BAR);
      if ($urandom_range(0, 7) != 0) send_ch(CH_BAR);
    end else if (k == 11) begin
      send_ch($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
    end else if (k <= 14) begin
      case ($urandom_range(0, 2))
        0: send_ch(CH_SPACE);
        1: send_ch(CH_TAB);
        default: send_ch(CH_LF);
      endcase
    end else if (k == 15) begin
      send_ch(8'($urandom_range(1, 255)));
    end else if (k == 16) begin
      if ($urandom_range(0, 1) == 1) send_beat('{8'($urandom_range(0, 255)), 1'b1}, 1'b0, NO_RES);
      else send_ch(CH_NUL);
    end else begin
      send_beat('{8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0}, 1'b0, NO_RES);
    end
  endtask

  initial begin
    int start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_beat(dir_tab[i].beat, dir_tab[i].pinned, dir_tab[i].res);
    wait_drained();

    // long receiver hold while braces keep coming
    hold_off_req = 1'b1;
    tx_rush = 1'b1;
    repeat (12) send_ch($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE);
    tx_rush = 1'b0;
    wait_drained();

    start = beats_sent;
    while (beats_sent - start < RAND_BEATS) lex_snippet();

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && tok_exp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
